// File: design/cttc_pkg.sv
// Shared types, character codes and helper functions for the cell text type classifier.
`timescale 1ns / 1ps

package cttc_pkg;

  // Type code given for each cell.
  typedef enum logic [2:0] {
    CT_EMPTY   = 3'd0,
    CT_FORMULA = 3'd1,
    CT_STRING  = 3'd2,
    CT_DATE    = 3'd3,
    CT_DOUBLE  = 3'd4,
    CT_INTEGER = 3'd5,
    CT_UNKNOWN = 3'd6
  } cell_type_t;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UC_C   = 8'h43;
  localparam logic [7:0] CH_UC_R   = 8'h52;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_C   = 8'h63;
  localparam logic [7:0] CH_LC_R   = 8'h72;

  // Bit positions of the quoted-string flags.
  localparam int Q_ALIVE = 0;
  localparam int Q_ESC   = 1;
  localparam int Q_PQ    = 2;

  // Bit positions of the number flags.
  localparam int N_BAD    = 0;
  localparam int N_DOT    = 1;
  localparam int N_BEFORE = 2;
  localparam int N_AFTER  = 3;

  // Date parts, length limits and sizes.
  localparam int NUM_PARTS = 3;
  localparam logic [6:0] TLEN_MAX = 7'd127;
  localparam logic [2:0] PLEN_MAX = 3'd7;
  localparam logic [2:0] PLEN_VAL = 3'd4;
  localparam logic [1:0] DASH_MAX = 2'd3;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic formula_char(input logic [7:0] c);
    formula_char = c inside {[CH_ZERO:CH_NINE], CH_PLUS, CH_DASH, CH_STAR, CH_SLASH,
                             CH_EQ, CH_BANG, CH_LT, CH_GT, CH_DOT, CH_UC_R, CH_LC_R,
                             CH_UC_C, CH_LC_C, CH_LPAREN, CH_RPAREN, CH_SPACE, CH_TAB,
                             CH_LF, CH_CR};
  endfunction

  // One inner byte of the quoted-string test, after the opening quote.
  function automatic logic [2:0] quote_inner(input logic [2:0] f, input logic [7:0] c);
    logic [2:0] r;
    r = f;
    if (f[Q_ALIVE]) begin
      if (f[Q_PQ]) begin
        r = 3'b000;
      end else if (f[Q_ESC]) begin
        r = 3'b001;
      end else if (c == CH_BSLASH) begin
        r = 3'b011;
      end else if (c == CH_QUOTE) begin
        r = 3'b101;
      end
    end
    quote_inner = r;
  endfunction

  // Days in a month (1 to 12) of a common year.
  function automatic logic [4:0] month_days(input logic [3:0] month);
    logic [4:0] d;
    case (month)
      4'd2: begin
        d = 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        d = 5'd30;
      end
      default: begin
        d = 5'd31;
      end
    endcase
    month_days = d;
  endfunction

  // Date check for one reading of the three parts.
  function automatic logic valid_date(input logic [13:0] day, input logic [13:0] month,
                                      input logic [13:0] year, input logic leap);
    logic [4:0] maxd;
    maxd = month_days(month[3:0]);
    if (month == 14'd2 && leap) begin
      maxd = 5'd29;
    end
    valid_date = (year != 14'd0) && (month >= 14'd1) && (month <= 14'd12) &&
                 (day != 14'd0) && (day <= 14'(maxd));
  endfunction

endpackage

// File: design/cell_text_type_classifier.sv
// Top level of the cell text type classifier: input register, per-byte update, result register.
`timescale 1ns / 1ps

// Takes the text of one spreadsheet cell a byte per beat, with the final byte marked by
// in_last_byte, and returns one type code per cell (empty, formula, quoted string, date,
// double, integer, unknown). Blanks at both ends are trimmed and a zero byte ends the text.
// One byte is taken every cycle unless the input is stalled: each byte is held in an input
// register, folded into a handful of running flags and small counters by a short piece of
// logic, and the type of a finished cell lands in the result register once its last byte leaves
// the input register. The result register lets the next cell stream in while a type still
// waits; only a second last byte arriving while that type is still stalled holds the input.
module cell_text_type_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_cell_type
);
  import cttc_pkg::*;

  // Input register.
  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_go, s1_fire, cell_done;

  // Per-cell state.
  logic       text_ended_r, text_ended_nxt;
  logic       nonspace_r, nonspace_nxt;
  logic       space_pend_r, space_pend_nxt;
  logic       inner_space_r, inner_space_nxt;
  logic [6:0] tlen_r, tlen_nxt;
  logic       formula_ok_r, formula_ok_nxt;
  logic [2:0] quote_r, quote_nxt;
  logic [3:0] num_r, num_nxt;
  logic [1:0] dash_r, dash_nxt;
  logic       date_ok_r, date_ok_nxt;
  logic       first_c;
  logic [3:0] digit_c;

  // Per-part date lanes; last two digits and older values mod 4 feed the leap-year test.
  logic [2:0]  plen_r [0:NUM_PARTS-1];
  logic [2:0]  plen_nxt [0:NUM_PARTS-1];
  logic [13:0] pval_r [0:NUM_PARTS-1];
  logic [13:0] pval_nxt [0:NUM_PARTS-1];
  logic [3:0]  ld_r [0:NUM_PARTS-1];
  logic [3:0]  ld_nxt [0:NUM_PARTS-1];
  logic [3:0]  pd_r [0:NUM_PARTS-1];
  logic [3:0]  pd_nxt [0:NUM_PARTS-1];
  logic [1:0]  m1_r [0:NUM_PARTS-1];
  logic [1:0]  m1_nxt [0:NUM_PARTS-1];
  logic [1:0]  m2_r [0:NUM_PARTS-1];
  logic [1:0]  m2_nxt [0:NUM_PARTS-1];
  logic [NUM_PARTS-1:0] leap_c;

  // Classification and result register.
  logic       pat_c, date_c;
  cell_type_t type_c;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_type_r;

  // A last byte moves on only when the result register is free or being emptied.
  assign s1_go     = !s1_last_r || !out_valid_r || !out_stall;
  assign s1_fire   = s1_vld_r && s1_go;
  assign cell_done = s1_fire && s1_last_r;
  assign in_stall  = s1_vld_r && !s1_go;
  assign s1_vld_nxt = in_stall ? s1_vld_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_text_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Fold the held byte into the running state.
  assign digit_c = 4'(s1_byte_r - CH_ZERO);

  always_comb begin
    text_ended_nxt  = text_ended_r;
    nonspace_nxt    = nonspace_r;
    space_pend_nxt  = space_pend_r;
    inner_space_nxt = inner_space_r;
    tlen_nxt        = tlen_r;
    formula_ok_nxt  = formula_ok_r;
    quote_nxt       = quote_r;
    num_nxt         = num_r;
    dash_nxt        = dash_r;
    date_ok_nxt     = date_ok_r;
    first_c         = 1'b0;
    for (int i = 0; i < NUM_PARTS; i++) begin
      plen_nxt[i] = plen_r[i];
      pval_nxt[i] = pval_r[i];
      ld_nxt[i]   = ld_r[i];
      pd_nxt[i]   = pd_r[i];
      m1_nxt[i]   = m1_r[i];
      m2_nxt[i]   = m2_r[i];
    end

    if (!text_ended_r) begin
      if (s1_byte_r == CH_NUL) begin
        text_ended_nxt = 1'b1;
      end else if (is_blank(s1_byte_r)) begin
        if (nonspace_r) begin
          space_pend_nxt = 1'b1;
        end
      end else begin
        // Pending blanks turn out to be inner ones.
        if (space_pend_r) begin
          space_pend_nxt  = 1'b0;
          inner_space_nxt = 1'b1;
          quote_nxt       = quote_inner(quote_nxt, CH_SPACE);
          if (tlen_nxt < TLEN_MAX) begin
            tlen_nxt = tlen_nxt + 7'd1;
          end
        end
        first_c = (tlen_nxt == 7'd0);

        // Formula test.
        if (first_c) begin
          formula_ok_nxt = (s1_byte_r == CH_EQ);
        end else if (!formula_char(s1_byte_r)) begin
          formula_ok_nxt = 1'b0;
        end

        // Quoted-string test.
        if (first_c) begin
          quote_nxt = (s1_byte_r == CH_QUOTE) ? 3'b001 : 3'b000;
        end else begin
          quote_nxt = quote_inner(quote_nxt, s1_byte_r);
        end

        // Date parts.
        if (s1_byte_r == CH_DASH) begin
          if (dash_r < DASH_MAX) begin
            dash_nxt = dash_r + 2'd1;
          end
        end else if (is_digit(s1_byte_r)) begin
          for (int i = 0; i < NUM_PARTS; i++) begin
            if (dash_r == 2'(i)) begin
              if (plen_r[i] < PLEN_MAX) begin
                plen_nxt[i] = plen_r[i] + 3'd1;
              end
              if (plen_nxt[i] <= PLEN_VAL) begin
                pval_nxt[i] = pval_r[i] * 14'd10 + 14'(digit_c);
                ld_nxt[i]   = digit_c;
                pd_nxt[i]   = ld_r[i];
                m1_nxt[i]   = pval_r[i][1:0];
                m2_nxt[i]   = m1_r[i];
              end
            end
          end
        end else begin
          date_ok_nxt = 1'b0;
        end

        // Number test.
        if (first_c && (s1_byte_r == CH_PLUS || s1_byte_r == CH_DASH)) begin
          num_nxt = num_r;
        end else if (is_digit(s1_byte_r)) begin
          if (num_r[N_DOT]) begin
            num_nxt[N_AFTER] = 1'b1;
          end else begin
            num_nxt[N_BEFORE] = 1'b1;
          end
        end else if (s1_byte_r == CH_DOT && !num_r[N_DOT]) begin
          num_nxt[N_DOT] = 1'b1;
        end else begin
          num_nxt[N_BAD] = 1'b1;
        end

        nonspace_nxt = 1'b1;
        if (tlen_nxt < TLEN_MAX) begin
          tlen_nxt = tlen_nxt + 7'd1;
        end
      end
    end
  end

  // Leap year per part: divisible by 4 and not by 100, or by 400.
  always_comb begin
    for (int i = 0; i < NUM_PARTS; i++) begin
      leap_c[i] = ((pval_nxt[i][1:0] == 2'd0) && !(ld_nxt[i] == 4'd0 && pd_nxt[i] == 4'd0)) ||
                  ((ld_nxt[i] == 4'd0) && (pd_nxt[i] == 4'd0) && (m2_nxt[i] == 2'd0));
    end
  end

  // Date: two dashes, 2-2-4 or 4-2-2 digits, valid under either reading.
  assign pat_c = (plen_nxt[0] == 3'd2 && plen_nxt[1] == 3'd2 && plen_nxt[2] == 3'd4) ||
                 (plen_nxt[0] == 3'd4 && plen_nxt[1] == 3'd2 && plen_nxt[2] == 3'd2);
  assign date_c = (dash_nxt == 2'd2) && date_ok_nxt && !inner_space_nxt && pat_c &&
                  (valid_date(pval_nxt[2], pval_nxt[1], pval_nxt[0], leap_c[0]) ||
                   valid_date(pval_nxt[0], pval_nxt[1], pval_nxt[2], leap_c[2]));

  // Priority order of the type tests.
  always_comb begin
    if (!nonspace_nxt) begin
      type_c = CT_EMPTY;
    end else if (formula_ok_nxt && tlen_nxt >= 7'd2) begin
      type_c = CT_FORMULA;
    end else if (quote_nxt[Q_ALIVE] && quote_nxt[Q_PQ]) begin
      type_c = CT_STRING;
    end else if (date_c) begin
      type_c = CT_DATE;
    end else if (!inner_space_nxt && !num_nxt[N_BAD] && num_nxt[N_DOT] &&
                 num_nxt[N_BEFORE] && num_nxt[N_AFTER]) begin
      type_c = CT_DOUBLE;
    end else if (!inner_space_nxt && !num_nxt[N_BAD] && !num_nxt[N_DOT] &&
                 num_nxt[N_BEFORE]) begin
      type_c = CT_INTEGER;
    end else begin
      type_c = CT_UNKNOWN;
    end
  end

  // State registers; a finished cell puts them back to their start values.
  always_ff @(posedge clk) begin
    if (!rst_n || cell_done) begin
      text_ended_r  <= 1'b0;
      nonspace_r    <= 1'b0;
      space_pend_r  <= 1'b0;
      inner_space_r <= 1'b0;
      tlen_r        <= 7'd0;
      formula_ok_r  <= 1'b1;
      quote_r       <= 3'b000;
      num_r         <= 4'b0000;
      dash_r        <= 2'd0;
      date_ok_r     <= 1'b1;
      for (int i = 0; i < NUM_PARTS; i++) begin
        plen_r[i] <= 3'd0;
        pval_r[i] <= 14'd0;
        ld_r[i]   <= 4'd0;
        pd_r[i]   <= 4'd0;
        m1_r[i]   <= 2'd0;
        m2_r[i]   <= 2'd0;
      end
    end else if (s1_fire) begin
      text_ended_r  <= text_ended_nxt;
      nonspace_r    <= nonspace_nxt;
      space_pend_r  <= space_pend_nxt;
      inner_space_r <= inner_space_nxt;
      tlen_r        <= tlen_nxt;
      formula_ok_r  <= formula_ok_nxt;
      quote_r       <= quote_nxt;
      num_r         <= num_nxt;
      dash_r        <= dash_nxt;
      date_ok_r     <= date_ok_nxt;
      for (int i = 0; i < NUM_PARTS; i++) begin
        plen_r[i] <= plen_nxt[i];
        pval_r[i] <= pval_nxt[i];
        ld_r[i]   <= ld_nxt[i];
        pd_r[i]   <= pd_nxt[i];
        m1_r[i]   <= m1_nxt[i];
        m2_r[i]   <= m2_nxt[i];
      end
    end
  end

  // Result register.
  always_comb begin
    if (cell_done) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_done) begin
      out_type_r <= 3'(type_c);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_type = out_type_r;

`ifndef SYNTHESIS
  // The input only waits on a last byte blocked by an unread result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && s1_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // A finished cell always leaves a result in the output register.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cell_done |=> out_valid_r)
    else $error("finished cell left no result");

  // A finished cell restarts the running state.
  a_state_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cell_done |=> (tlen_r == 7'd0 && !nonspace_r && !text_ended_r && dash_r == 2'd0))
    else $error("cell state not restarted");

  // The trimmed length counts kept bytes, so it is nonzero exactly after a non-blank byte.
  a_len_nonspace: assert property (@(posedge clk) disable iff (!rst_n)
    nonspace_r == (tlen_r != 7'd0))
    else $error("length and non-blank flag disagree");

  // Blanks are held as pending only after some non-blank byte.
  a_pend_after_text: assert property (@(posedge clk) disable iff (!rst_n)
    space_pend_r |-> nonspace_r)
    else $error("leading blank held as pending");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for the cell text type classifier.
`timescale 1ns / 1ps

module tb;
  import cttc_pkg::*;

  localparam int ITEM_TARGET = 1200;
  localparam int GAP_MAX     = 17;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 8;

  // One input beat waiting to be offered, with the idle cycles that precede it.
  typedef struct {
    logic [7:0] text;
    logic       last;
    int         gap;
    bit         drain;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = '0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_cell_type;

  cell_text_type_classifier i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_type (out_cell_type)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus and expected cell types.
  beat_t      beats_q[$];
  logic [7:0] cell_bytes[$];
  cell_type_t types_due[$];
  string      formula_set = "0123456789+-*/=!<>.RrCc() ";
  string      quote_set = "abcxyz12 \\\"";
  string      mix_set = "0123456789-.+ ";
  int         month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Bookkeeping.
  int fails = 0;
  int beats_in = 0;
  int cells_seen = 0;
  int cells_built = 0;
  int stall_cycles = 0;
  int holds = 0;
  int drains = 0;
  int quiet = 0;
  int type_tally [7] = '{0, 0, 0, 0, 0, 0, 0};

  // Running state of the cell being predicted.
  logic        text_done;
  logic        any_text;
  logic        blank_held;
  logic        inner_blank;
  logic [6:0]  kept_len;
  logic        eq_ok;
  logic [2:0]  q_flags;
  logic [3:0]  n_flags;
  logic [1:0]  dashes;
  logic [2:0]  seg_len [NUM_PARTS];
  logic [13:0] seg_val [NUM_PARTS];
  logic        all_digits;

  function automatic logic blank_ch(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic formula_ch(input logic [7:0] c);
    case (c)
      CH_PLUS, CH_DASH, CH_STAR, CH_SLASH, CH_EQ, CH_BANG, CH_LT, CH_GT, CH_DOT,
      CH_UC_R, CH_LC_R, CH_UC_C, CH_LC_C, CH_LPAREN, CH_RPAREN: begin
        return 1'b1;
      end
      default: begin
        return digit_ch(c) || blank_ch(c);
      end
    endcase
  endfunction

  // Quoted-string flags after one byte inside the opening quote.
  function automatic logic [2:0] quote_next(input logic [2:0] f, input logic [7:0] c);
    logic [2:0] r;
    r = f;
    if (f[Q_ALIVE]) begin
      if (f[Q_PQ]) begin
        r = '0;
      end else if (f[Q_ESC]) begin
        r[Q_ESC] = 1'b0;
      end else if (c == CH_BSLASH) begin
        r[Q_ESC] = 1'b1;
      end else if (c == CH_QUOTE) begin
        r[Q_PQ] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic bit date_ok(input int d, input int m, input int y);
    int  top;
    bit  leap;
    if (y < 1 || m < 1 || m > 12 || d < 1) begin
      return 1'b0;
    end
    top = month_len[m - 1];
    leap = (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    if (m == 2 && leap) begin
      top = 29;
    end
    return d <= top;
  endfunction

  task clear_cell();
    text_done = 1'b0;
    any_text = 1'b0;
    blank_held = 1'b0;
    inner_blank = 1'b0;
    kept_len = '0;
    eq_ok = 1'b1;
    q_flags = '0;
    n_flags = '0;
    dashes = '0;
    all_digits = 1'b1;
    for (int k = 0; k < NUM_PARTS; k++) begin
      seg_len[k] = '0;
      seg_val[k] = '0;
    end
  endtask

  // Fold one non-blank byte into every running test.
  task take_text(input logic [7:0] c);
    logic first;
    // Blanks held back turn out to be inner ones and count as a single space.
    if (blank_held) begin
      blank_held = 1'b0;
      inner_blank = 1'b1;
      q_flags = quote_next(q_flags, CH_SPACE);
      if (kept_len != TLEN_MAX) begin
        kept_len++;
      end
    end
    first = (kept_len == '0);

    if (first) begin
      eq_ok = (c == CH_EQ);
      q_flags = '0;
      q_flags[Q_ALIVE] = (c == CH_QUOTE);
    end else begin
      if (!formula_ch(c)) begin
        eq_ok = 1'b0;
      end
      q_flags = quote_next(q_flags, c);
    end

    // Date parts are split by dashes; long parts keep only their first four digits.
    if (c == CH_DASH) begin
      if (dashes != DASH_MAX) begin
        dashes++;
      end
    end else if (digit_ch(c)) begin
      if (dashes != DASH_MAX) begin
        if (seg_len[dashes] != PLEN_MAX) begin
          seg_len[dashes]++;
        end
        if (seg_len[dashes] <= PLEN_VAL) begin
          seg_val[dashes] = seg_val[dashes] * 14'd10 + 14'(c - CH_ZERO);
        end
      end
    end else begin
      all_digits = 1'b0;
    end

    // A sign at the first position leaves the number flags alone.
    if (!(first && (c == CH_PLUS || c == CH_DASH))) begin
      if (digit_ch(c)) begin
        if (n_flags[N_DOT]) begin
          n_flags[N_AFTER] = 1'b1;
        end else begin
          n_flags[N_BEFORE] = 1'b1;
        end
      end else if (c == CH_DOT && !n_flags[N_DOT]) begin
        n_flags[N_DOT] = 1'b1;
      end else begin
        n_flags[N_BAD] = 1'b1;
      end
    end

    any_text = 1'b1;
    if (kept_len != TLEN_MAX) begin
      kept_len++;
    end
  endtask

  // Type of the finished cell, tests taken in priority order.
  function automatic cell_type_t cell_class();
    bit is_date;
    is_date = 1'b0;
    if (!any_text) begin
      return CT_EMPTY;
    end
    if (eq_ok && kept_len >= 7'd2) begin
      return CT_FORMULA;
    end
    if (q_flags[Q_ALIVE] && q_flags[Q_PQ]) begin
      return CT_STRING;
    end
    if (dashes == 2'd2 && all_digits && !inner_blank) begin
      if ((seg_len[0] == 3'd2 && seg_len[1] == 3'd2 && seg_len[2] == 3'd4) ||
          (seg_len[0] == 3'd4 && seg_len[1] == 3'd2 && seg_len[2] == 3'd2)) begin
        is_date = date_ok(seg_val[2], seg_val[1], seg_val[0]) ||
                  date_ok(seg_val[0], seg_val[1], seg_val[2]);
      end
    end
    if (is_date) begin
      return CT_DATE;
    end
    if (!inner_blank && !n_flags[N_BAD]) begin
      if (n_flags[N_DOT] && n_flags[N_BEFORE] && n_flags[N_AFTER]) begin
        return CT_DOUBLE;
      end
      if (!n_flags[N_DOT] && n_flags[N_BEFORE]) begin
        return CT_INTEGER;
      end
    end
    return CT_UNKNOWN;
  endfunction

  // Update the prediction with one accepted beat; the last beat yields a cell type.
  task predict_beat(input logic [7:0] c, input logic last);
    cell_type_t t;
    if (!text_done) begin
      if (c == CH_NUL) begin
        text_done = 1'b1;
      end else if (blank_ch(c)) begin
        if (any_text) begin
          blank_held = 1'b1;
        end
      end else begin
        take_text(c);
      end
    end
    if (last) begin
      t = cell_class();
      types_due.push_back(t);
      type_tally[int'(t)]++;
      clear_cell();
    end
  endtask

  task report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fails++;
  endtask

  // Turn the collected bytes into beats; some cells are sent without any idling.
  task emit_cell(input bit drain);
    beat_t b;
    bit    calm;
    calm = ($urandom_range(0, 3) == 0);
    foreach (cell_bytes[i]) begin
      b.text = cell_bytes[i];
      b.last = (i == cell_bytes.size() - 1);
      b.gap = calm ? 0 : $urandom_range(0, GAP_MAX);
      b.drain = drain && (i == 0);
      beats_q.push_back(b);
    end
    cell_bytes.delete();
    cells_built++;
  endtask

  task add_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      cell_bytes.push_back(s[i]);
    end
  endtask

  task cell_str(input string s);
    add_str(s);
    emit_cell(1'b0);
  endtask

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  task add_pad();
    repeat ($urandom_range(0, 2)) cell_bytes.push_back(any_blank());
  endtask

  task add_digits(input int n);
    repeat (n) cell_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // One random cell: mostly well-formed text of each type, some noise and breakage.
  task gen_cell(input bit drain);
    int    kind;
    int    d;
    int    m;
    int    y;
    string s;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 2) == 0) begin
      add_pad();
    end
    case (kind)
      0: begin
        if ($urandom_range(0, 2) == 0) begin
          cell_bytes.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
        end
        add_digits($urandom_range(1, 6));
      end
      1: begin
        if ($urandom_range(0, 2) == 0) begin
          cell_bytes.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
        end
        add_digits(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4));
        cell_bytes.push_back(CH_DOT);
        add_digits(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4));
      end
      2, 3: begin
        d = $urandom_range(0, 1) ? $urandom_range(27, 31) : $urandom_range(0, 32);
        m = ($urandom_range(0, 2) == 0) ? 2 : $urandom_range(0, 13);
        case ($urandom_range(0, 7))
          0: y = 0;
          1: y = 1900;
          2: y = 2000;
          3: y = 2024;
          4: y = 2023;
          5: y = 9999;
          default: y = $urandom_range(1, 9999);
        endcase
        if ($urandom_range(0, 7) == 0) begin
          s = $sformatf("%0d-%0d-%0d", $urandom_range(0, 99999), $urandom_range(0, 999),
                        $urandom_range(0, 99999));
        end else if ($urandom_range(0, 1)) begin
          s = $sformatf("%02d-%02d-%04d", d, m, y);
        end else begin
          s = $sformatf("%04d-%02d-%02d", y, m, d);
        end
        add_str(s);
      end
      4: begin
        cell_bytes.push_back(CH_EQ);
        repeat ($urandom_range(0, 8)) begin
          cell_bytes.push_back(formula_set[$urandom_range(0, formula_set.len() - 1)]);
        end
      end
      5: begin
        cell_bytes.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          cell_bytes.push_back(quote_set[$urandom_range(0, quote_set.len() - 1)]);
        end
        if ($urandom_range(0, 5) != 0) begin
          cell_bytes.push_back(CH_QUOTE);
        end
      end
      6: begin
        repeat ($urandom_range(0, 3)) cell_bytes.push_back(any_blank());
      end
      7, 8: begin
        repeat ($urandom_range(1, 8)) cell_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        repeat ($urandom_range(1, 12)) begin
          cell_bytes.push_back(mix_set[$urandom_range(0, mix_set.len() - 1)]);
        end
      end
    endcase
    if ($urandom_range(0, 2) == 0) begin
      add_pad();
    end
    // Occasional damage: a random byte, or a zero byte that ends the text early.
    if (cell_bytes.size() != 0 && $urandom_range(0, 9) == 0) begin
      cell_bytes[$urandom_range(0, cell_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if (cell_bytes.size() != 0 && $urandom_range(0, 19) == 0) begin
      cell_bytes.insert($urandom_range(0, cell_bytes.size() - 1), CH_NUL);
    end
    if (cell_bytes.size() == 0) begin
      cell_bytes.push_back(any_blank());
    end
    emit_cell(drain);
  endtask

  // Driver: offers queued beats, idling before each as drawn, holding a stalled beat.
  beat_t drv_beat;
  int    gap_left = -1;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_beat(in_text_byte, in_last_byte);
        beats_in++;
      end else if (in_valid) begin
        stall_cycles++;
      end
      if (!in_valid || !in_stall) begin
        if (beats_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          if (gap_left < 0) begin
            gap_left = beats_q[0].gap;
          end
          if (gap_left > 0) begin
            gap_left--;
            in_valid <= 1'b0;
          end else if (beats_q[0].drain && types_due.size() != 0) begin
            // Pause until every cell sent so far has returned its type.
            in_valid <= 1'b0;
          end else begin
            drv_beat = beats_q.pop_front();
            if (drv_beat.drain) begin
              drains++;
            end
            in_valid <= 1'b1;
            in_text_byte <= drv_beat.text;
            in_last_byte <= drv_beat.last;
            gap_left = -1;
          end
        end
      end
    end
  end

  // Monitor: checks each cell type and draws the receiver's stall.
  cell_type_t want;
  int         stall_left = 0;
  int         hold_left = 0;
  bit         calm_rx = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        cells_seen++;
        if (types_due.size() == 0) begin
          report_mismatch($sformatf("cell type %0d returned with no cell pending",
                                    out_cell_type));
        end else begin
          want = types_due.pop_front();
          if (out_cell_type !== want) begin
            report_mismatch($sformatf("cell %0d: type %0d, expected %0d (%s)", cells_seen,
                                      out_cell_type, want, want.name()));
          end
        end
        stall_left = calm_rx ? 0 : $urandom_range(0, GAP_MAX);
        if (cells_seen % 16 == 0) begin
          calm_rx = ($urandom_range(0, 2) == 0);
        end
        // Long hold-off so that the block fills up and stalls its input.
        if (cells_seen == 30 || cells_seen == 120) begin
          hold_left = HOLD_CYCLES;
          holds++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with neither an accepted beat nor a returned cell type.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("Watchdog: nothing accepted for %0d cycles, %0d cell types outstanding",
                 quiet, types_due.size());
        $display("cell_text_type_classifier: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int n0;
    int c0;
    clear_cell();

    // Directed cells: blanks and empty text.
    cell_bytes.push_back(CH_SPACE);
    emit_cell(1'b0);
    cell_bytes.push_back(CH_NUL);
    emit_cell(1'b0);
    cell_bytes = '{CH_TAB, CH_CR, CH_LF, CH_SPACE};
    emit_cell(1'b0);
    // Formulas, a lone equals sign and a bad formula byte.
    cell_str("= 1+r2C3 *(4-5)/6<>!.");
    cell_str("=");
    cell_str("=A1");
    // Quoted strings: plain, escaped inner quote, escaped closing quote, bare inner
    // quote, empty quotes, and an escape consumed by an inner blank.
    cell_str("\"abc\"");
    cell_str("\"a\\\"b\"");
    cell_str("\"ab\\\"");
    cell_str("\"a\"b\"");
    cell_str("\"\"");
    cell_str("\"\\  \"");
    // Dates: leap days, year zero, upper extremes and an over-long part.
    cell_str("29-02-2024");
    cell_str("1900-02-29");
    cell_str("2000-02-29");
    cell_str("0000-01-01");
    cell_str("31-12-9999");
    cell_str("12345-01-01");
    // Numbers and broken numbers.
    cell_str("-12.5");
    cell_str("+7");
    cell_str("1.");
    cell_str(".5");
    cell_str("-");
    cell_str("12 34");
    // Trimming at both ends.
    cell_bytes = '{CH_SPACE, CH_SPACE};
    add_str("42");
    cell_bytes.push_back(CH_TAB);
    cell_bytes.push_back(CH_CR);
    cell_bytes.push_back(CH_LF);
    emit_cell(1'b0);
    // A zero byte ends the text, also when it is the last byte.
    add_str("12");
    cell_bytes.push_back(CH_NUL);
    add_str("abc");
    emit_cell(1'b0);
    add_str("7");
    cell_bytes.push_back(CH_NUL);
    emit_cell(1'b0);
    cell_bytes.push_back(8'hFF);
    emit_cell(1'b0);
    // Text long enough to saturate the length count.
    cell_bytes.push_back(CH_EQ);
    add_digits(129);
    emit_cell(1'b0);

    // Random cells; the first and every so often another wait for the block to drain.
    n0 = beats_q.size();
    c0 = cells_built;
    while (beats_q.size() - n0 < ITEM_TARGET) begin
      gen_cell((cells_built - c0) % 150 == 0);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every built cell has returned a type; the watchdog catches a lost one.
    while (cells_seen < cells_built) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (types_due.size() != 0 || beats_q.size() != 0 || in_valid) begin
      report_mismatch($sformatf("%0d cell types and %0d beats left at the end",
                                types_due.size(), beats_q.size()));
    end

    $display("Checked %0d cells in %0d beats; input stalled %0d cycles, %0d hold-offs, %0d drains.",
             cells_seen, beats_in, stall_cycles, holds, drains);
    $display("Types: empty %0d, formula %0d, string %0d, date %0d, double %0d, integer %0d, unknown %0d",
             type_tally[0], type_tally[1], type_tally[2], type_tally[3], type_tally[4],
             type_tally[5], type_tally[6]);
    if (fails == 0) begin
      $display("cell_text_type_classifier: match");
    end else begin
      $display("cell_text_type_classifier: mismatch");
    end
    $finish;
  end

endmodule
